### hdl/pcd3d_pkg.sv
// Shared types, constants and helpers for the periodic central-difference gradient block.
package pcd3d_pkg;

    // Grid geometry; GRID_SIDE is a power of two (coordinates wrap by masking).
    localparam int GRID_SIDE  = 32;
    localparam int COORD_IN_W = 5;
    localparam int CW         = $clog2(GRID_SIDE);
    localparam int ADDR_W     = 3 * CW;
    localparam int CELLS      = GRID_SIDE * GRID_SIDE * GRID_SIDE;

    // Data widths
    localparam int DATA_W = 32;
    localparam int INV_W  = 24;
    localparam int AXIS_W = 2;
    localparam int DIFF_W = DATA_W + 1;
    localparam int PROD_W = DIFF_W + INV_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int FRAC_W = 16;
    localparam int GRAD_W = SUM_W - FRAC_W;

    localparam logic signed [SUM_W-1:0]  ROUND_HALF = SUM_W'(1) <<< (FRAC_W - 1);
    localparam logic signed [DATA_W-1:0] GRAD_MAX   = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] GRAD_MIN   = {1'b1, {(DATA_W-1){1'b0}}};

    // Outstanding queries / result queue
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // Config port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_AXIS = 1'b0;
    localparam logic REG_INV  = 1'b1;

    localparam logic [INV_W-1:0]  INV_RESET  = INV_W'(32768);
    localparam logic [AXIS_W-1:0] AXIS_RESET = '0;

    // Codes
    localparam logic [AXIS_W-1:0] AXIS_A = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_B = 2'd1;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_SECOND
    } t_state;

    typedef struct packed {
        logic              wr;
        logic              rd;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } t_mem_req;

    typedef struct packed {
        logic              saturated;
        logic [DATA_W-1:0] gradient;
    } t_result;

    function automatic logic [CW-1:0] mask_coord(input logic [COORD_IN_W-1:0] v);
        logic [CW+COORD_IN_W-1:0] t;
        t = (CW + COORD_IN_W)'(v);
        return t[CW-1:0];
    endfunction

endpackage

### hdl/pcd3d_grid.sv
// Single-port potential grid memory with a registered read.
module pcd3d_grid (
    input  logic                          i_clk,
    input  pcd3d_pkg::t_mem_req           i_req,
    output logic [pcd3d_pkg::DATA_W-1:0]  o_rdata
);
    import pcd3d_pkg::*;

    logic [DATA_W-1:0] r_mem [CELLS];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/pcd3d_arith.sv
// Difference, scale, round and saturate pipeline for one gradient.
module pcd3d_arith (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_take_plus,
    input  logic [pcd3d_pkg::DATA_W-1:0] i_rdata,
    input  logic [pcd3d_pkg::INV_W-1:0]  i_inv,
    output logic                         o_vld,
    output pcd3d_pkg::t_result           o_res
);
    import pcd3d_pkg::*;

    logic                     r_v1, r_v2, r_v3, r_v4;
    logic [DATA_W-1:0]        r_plus;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [PROD_W-1:0] r_prod;
    t_result                  r_res;

    logic signed [DIFF_W-1:0] w_diff;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [SUM_W-1:0]  w_sum;
    logic signed [GRAD_W-1:0] w_grad;
    logic                     w_fits;
    t_result                  w_res;

    // plus neighbor arrives first, minus in the cycle after
    assign w_diff = $signed({r_plus[DATA_W-1], r_plus}) - $signed({i_rdata[DATA_W-1], i_rdata});
    assign w_prod = r_diff * $signed({1'b0, i_inv});

    // round half up, then floor shift
    assign w_sum  = $signed({r_prod[PROD_W-1], r_prod}) + ROUND_HALF;
    assign w_grad = w_sum[SUM_W-1:FRAC_W];
    assign w_fits = (&w_grad[GRAD_W-1:DATA_W-1]) || !(|w_grad[GRAD_W-1:DATA_W-1]);

    always_comb begin
        w_res.saturated = !w_fits;
        if (w_fits) begin
            w_res.gradient = w_grad[DATA_W-1:0];
        end else if (w_grad[GRAD_W-1]) begin
            w_res.gradient = GRAD_MIN;
        end else begin
            w_res.gradient = GRAD_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_take_plus;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take_plus) begin
            r_plus <= i_rdata;
        end
        if (r_v1) begin
            r_diff <= w_diff;
        end
        if (r_v2) begin
            r_prod <= w_prod;
        end
        if (r_v3) begin
            r_res <= w_res;
        end
    end

    assign o_vld = r_v4;
    assign o_res = r_res;

endmodule

### hdl/periodic_central_difference_3d.sv
// Top level: periodic central-difference gradient over a cubic potential grid.
//
//  channel   direction  handshake               payload
//  -------   ---------  ----------------------  -----------------------------------------
//  in        sink       i_in_valid / o_in_stall  i_action, i_coord_a/b/c, i_potential
//  out       source     o_out_valid / i_out_stall o_gradient, o_saturated
//  config    APB slave  psel/penable/pready      paddr, pwdata, prdata (axis, 1/(2h))
//
// A load is one grid write; a query makes two grid reads and stalls the input
// for the second, since both neighbor reads share the single grid port. A
// query's result passes through the reads, difference, multiply, round/saturate,
// then the result queue. Up to four queries may be outstanding; once four
// results are queued or in flight, o_in_stall holds until the output drains.
// Reset (synchronous, active low) clears control and configuration only: the
// grid has no reset or clearing pass; the user must have every cell loaded before use.
module periodic_central_difference_3d (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_action,
    input  logic [pcd3d_pkg::COORD_IN_W-1:0]      i_coord_a,
    input  logic [pcd3d_pkg::COORD_IN_W-1:0]      i_coord_b,
    input  logic [pcd3d_pkg::COORD_IN_W-1:0]      i_coord_c,
    input  logic signed [pcd3d_pkg::DATA_W-1:0]   i_potential,
    // output channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [pcd3d_pkg::DATA_W-1:0]   o_gradient,
    output logic                                  o_saturated,
    // config port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [pcd3d_pkg::PADDR_W-1:0]         paddr,
    input  logic [pcd3d_pkg::PDATA_W-1:0]         pwdata,
    output logic [pcd3d_pkg::PDATA_W-1:0]         prdata,
    output logic                                  pready
);
    import pcd3d_pkg::*;

    // ---------------- configuration registers ----------------
    logic [AXIS_W-1:0] r_axis_select;
    logic [INV_W-1:0]  r_inv_two_spacing;
    logic              w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis_select     <= AXIS_RESET;
            r_inv_two_spacing <= INV_RESET;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_AXIS: r_axis_select     <= pwdata[AXIS_W-1:0];
                REG_INV:  r_inv_two_spacing <= pwdata[INV_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_AXIS: prdata = PDATA_W'(r_axis_select);
            REG_INV:  prdata = PDATA_W'(r_inv_two_spacing);
            default:  prdata = '0;
        endcase
    end

    // ---------------- neighbor addresses ----------------
    logic [CW-1:0]     w_a, w_b, w_c;
    logic [CW-1:0]     w_ap, w_am, w_bp, w_bm, w_cp, w_cm;
    logic [ADDR_W-1:0] w_center, w_plus, w_minus;

    assign w_a = mask_coord(i_coord_a);
    assign w_b = mask_coord(i_coord_b);
    assign w_c = mask_coord(i_coord_c);

    // CW-bit add/subtract wraps around the periodic boundary
    always_comb begin
        w_ap = w_a;
        w_am = w_a;
        w_bp = w_b;
        w_bm = w_b;
        w_cp = w_c;
        w_cm = w_c;
        case (r_axis_select)
            AXIS_A: begin
                w_ap = w_a + CW'(1);
                w_am = w_a - CW'(1);
            end
            AXIS_B: begin
                w_bp = w_b + CW'(1);
                w_bm = w_b - CW'(1);
            end
            default: begin  // third index, code three included
                w_cp = w_c + CW'(1);
                w_cm = w_c - CW'(1);
            end
        endcase
    end

    assign w_center = {w_a, w_b, w_c};
    assign w_plus   = {w_ap, w_bp, w_cp};
    assign w_minus  = {w_am, w_bm, w_cm};

    // ---------------- sequencer ----------------
    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_minus_addr;
    logic [OUT_CNT_W-1:0] r_pending, n_pending;
    logic              w_in_xfer, w_query_xfer, w_out_xfer;
    t_mem_req          w_req;
    logic              w_take_plus;

    assign w_in_xfer    = i_in_valid && !o_in_stall;
    assign w_query_xfer = w_in_xfer && (i_action == ACT_QUERY);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (w_query_xfer) n_state = ST_SECOND;
            ST_SECOND: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = 1'b1;
        w_take_plus = 1'b0;
        w_req.wr    = 1'b0;
        w_req.rd    = 1'b0;
        w_req.addr  = w_center;
        w_req.wdata = i_potential;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = (r_pending == OUT_CNT_W'(OUT_DEPTH));
                if (w_in_xfer) begin
                    w_req.wr   = (i_action == ACT_LOAD);
                    w_req.rd   = (i_action == ACT_QUERY);
                    w_req.addr = (i_action == ACT_QUERY) ? w_plus : w_center;
                end
            end
            ST_SECOND: begin
                w_req.rd    = 1'b1;
                w_req.addr  = r_minus_addr;
                w_take_plus = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_query_xfer) begin
            r_minus_addr <= w_minus;
        end
    end

    // queries transferred in but whose result has not yet been transferred out
    assign n_pending = r_pending + OUT_CNT_W'(w_query_xfer) - OUT_CNT_W'(w_out_xfer);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    // ---------------- grid and arithmetic ----------------
    logic [DATA_W-1:0] w_rdata;
    logic              w_res_vld;
    t_result           w_res;

    pcd3d_grid u_grid (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    pcd3d_arith u_arith (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take_plus (w_take_plus),
        .i_rdata     (w_rdata),
        .i_inv       (r_inv_two_spacing),
        .o_vld       (w_res_vld),
        .o_res       (w_res)
    );

    // ---------------- result queue ----------------
    // Sized to the pending limit, so it never overflows.
    t_result              r_queue [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [OUT_CNT_W-1:0] r_q_cnt, n_q_cnt;

    assign o_out_valid = (r_q_cnt != '0);
    assign w_out_xfer  = o_out_valid && !i_out_stall;
    assign o_gradient  = $signed(r_queue[r_rd_ptr].gradient);
    assign o_saturated = r_queue[r_rd_ptr].saturated;
    assign n_q_cnt     = r_q_cnt + OUT_CNT_W'(w_res_vld) - OUT_CNT_W'(w_out_xfer);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_q_cnt  <= '0;
        end else begin
            r_q_cnt <= n_q_cnt;
            if (w_res_vld) begin
                r_wr_ptr <= r_wr_ptr + OUT_PTR_W'(1);
            end
            if (w_out_xfer) begin
                r_rd_ptr <= r_rd_ptr + OUT_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_vld) begin
            r_queue[r_wr_ptr] <= w_res;
        end
    end

endmodule

### hdl/pcd3d_checker.sv
// Port-level assertions for the gradient block, bound to the top level.
module pcd3d_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic                                i_action,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic signed [pcd3d_pkg::DATA_W-1:0] o_gradient,
    input logic                                o_saturated
);
    import pcd3d_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_gradient) && $stable(o_saturated)))
        else $error("stalled result changed");

    // second neighbor read occupies the grid port after a query transfer
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_action == ACT_QUERY) |=> o_in_stall)
        else $error("input taken during second neighbor read");

    // clipped results sit at a range limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |-> (o_gradient == GRAD_MAX || o_gradient == GRAD_MIN))
        else $error("saturated flag without a limit value");

    // reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind periodic_central_difference_3d pcd3d_checker u_pcd3d_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_action    (i_action),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_gradient  (o_gradient),
    .o_saturated (o_saturated)
);

### sim/gradient_checker.sv
`timescale 1ns / 1ps
// Checker for the central-difference gradient block: tracks loads and config, predicts, compares.
module gradient_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_stall,
    input  logic                                 i_action,
    input  logic [pcd3d_pkg::COORD_IN_W-1:0]     i_coord_a,
    input  logic [pcd3d_pkg::COORD_IN_W-1:0]     i_coord_b,
    input  logic [pcd3d_pkg::COORD_IN_W-1:0]     i_coord_c,
    input  logic signed [pcd3d_pkg::DATA_W-1:0]  i_potential,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_stall,
    input  logic signed [pcd3d_pkg::DATA_W-1:0]  i_gradient,
    input  logic                                 i_saturated,
    input  logic                                 i_psel,
    input  logic                                 i_penable,
    input  logic                                 i_pwrite,
    input  logic [pcd3d_pkg::PADDR_W-1:0]        i_paddr,
    input  logic [pcd3d_pkg::PDATA_W-1:0]        i_pwdata,
    input  logic [pcd3d_pkg::PDATA_W-1:0]        i_prdata,
    input  logic                                 i_pready,
    output int                                   o_pending,
    output int                                   o_mismatches
);
    import pcd3d_pkg::*;

    localparam longint ROUND_BIAS = longint'(1) <<< (FRAC_W - 1);

    logic signed [DATA_W-1:0] grid_copy [CELLS];
    logic [AXIS_W-1:0]        axis_reg;
    logic [INV_W-1:0]         inv_reg;
    t_result                  expected_gradients [$];
    int                       pending_count  = 0;
    int                       mismatch_count = 0;

    assign o_pending    = pending_count;
    assign o_mismatches = mismatch_count;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic int cell_addr(input int a, input int b, input int c);
        return ((a & (GRID_SIDE - 1)) * GRID_SIDE + (b & (GRID_SIDE - 1))) * GRID_SIDE
               + (c & (GRID_SIDE - 1));
    endfunction

    // (p[+1] - p[-1]) * inv, rounded half up, clipped to 32 bits
    function automatic t_result predict_gradient(input logic [COORD_IN_W-1:0] a,
                                                 input logic [COORD_IN_W-1:0] b,
                                                 input logic [COORD_IN_W-1:0] c);
        int      ap, am, bp, bm, cp, cm;
        longint  diff;
        longint  scaled;
        t_result res;
        ap = a; am = a; bp = b; bm = b; cp = c; cm = c;
        if (axis_reg == AXIS_A) begin
            ap = a + 1;
            am = a - 1;
        end else if (axis_reg == AXIS_B) begin
            bp = b + 1;
            bm = b - 1;
        end else begin
            // codes two and three both pick the third index
            cp = c + 1;
            cm = c - 1;
        end
        diff   = longint'(grid_copy[cell_addr(ap, bp, cp)])
               - longint'(grid_copy[cell_addr(am, bm, cm)]);
        scaled = (diff * longint'({40'd0, inv_reg}) + ROUND_BIAS) >>> FRAC_W;
        res.saturated = 1'b0;
        if (scaled > longint'(GRAD_MAX)) begin
            res.gradient  = GRAD_MAX;
            res.saturated = 1'b1;
        end else if (scaled < longint'(GRAD_MIN)) begin
            res.gradient  = GRAD_MIN;
            res.saturated = 1'b1;
        end else begin
            res.gradient = scaled[DATA_W-1:0];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        logic [PDATA_W-1:0] reg_val;
        if (!i_rst_n) begin
            axis_reg = AXIS_RESET;
            inv_reg  = INV_RESET;
            expected_gradients.delete();
        end else begin
            // retire results before queuing new ones
            if (i_out_valid && !i_out_stall) begin
                if (expected_gradients.size() == 0) begin
                    report_mismatch("unexpected result", i_gradient, 0);
                end else begin
                    want = expected_gradients.pop_front();
                    if (i_gradient !== want.gradient)
                        report_mismatch("gradient", i_gradient, want.gradient);
                    if (i_saturated !== want.saturated)
                        report_mismatch("saturated", i_saturated, want.saturated);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_action == ACT_LOAD)
                    grid_copy[cell_addr(i_coord_a, i_coord_b, i_coord_c)] = i_potential;
                else
                    expected_gradients.push_back(predict_gradient(i_coord_a, i_coord_b,
                                                                  i_coord_c));
            end
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (i_paddr[PADDR_W-1:2] == REG_AXIS)
                        axis_reg = i_pwdata[AXIS_W-1:0];
                    else
                        inv_reg = i_pwdata[INV_W-1:0];
                end else begin
                    reg_val = (i_paddr[PADDR_W-1:2] == REG_AXIS) ? PDATA_W'(axis_reg)
                                                                 : PDATA_W'(inv_reg);
                    if (i_prdata !== reg_val)
                        report_mismatch("register read", i_prdata, reg_val);
                end
            end
        end
        pending_count <= expected_gradients.size();
    end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// Testbench top: stimulus, config writes and the verdict for periodic_central_difference_3d.
module tb;
    import pcd3d_pkg::*;

    localparam int LIMIT_NS     = 2_000_000;  // far beyond the slowest correct run
    localparam int LONG_HOLD    = 300;        // cycles the sink refuses results
    localparam int SETTLE       = 8;          // a trailing load may still be in flight
    localparam int TAIL         = 20;
    localparam int RECENT_MAX   = 64;

    localparam logic [AXIS_W-1:0]  AXIS_C       = 2'd2;
    localparam logic [AXIS_W-1:0]  AXIS_C_ALIAS = 2'd3;  // decodes like the third index
    localparam logic [PADDR_W-1:0] ADDR_AXIS    = PADDR_W'({REG_AXIS, 2'b00});
    localparam logic [PADDR_W-1:0] ADDR_INV     = PADDR_W'({REG_INV, 2'b00});
    localparam logic               APB_WR       = 1'b1;
    localparam logic               APB_RD       = 1'b0;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic                     action    = ACT_LOAD;
    logic [COORD_IN_W-1:0]    coord_a   = '0;
    logic [COORD_IN_W-1:0]    coord_b   = '0;
    logic [COORD_IN_W-1:0]    coord_c   = '0;
    logic signed [DATA_W-1:0] potential = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] gradient;
    logic                     saturated;
    logic                     psel      = 1'b0;
    logic                     penable   = 1'b0;
    logic                     pwrite    = 1'b0;
    logic [PADDR_W-1:0]       paddr     = '0;
    logic [PDATA_W-1:0]       pwdata    = '0;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;

    int pending_results;
    int mismatch_count;

    // stimulus bookkeeping: which cells hold a sample, the axis in force, recent query cells
    bit                        cell_loaded [CELLS];
    logic [AXIS_W-1:0]         axis_now     = AXIS_RESET;
    logic [3*COORD_IN_W-1:0]   recent_cells [$];
    int                        item_count   = 0;
    bit                        src_idle_on  = 1'b1;
    bit                        sink_idle_on = 1'b1;
    int                        holds_asked  = 0;
    int                        holds_served = 0;

    always #2 clk = ~clk;

    periodic_central_difference_3d dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_action    (action),
        .i_coord_a   (coord_a),
        .i_coord_b   (coord_b),
        .i_coord_c   (coord_c),
        .i_potential (potential),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_gradient  (gradient),
        .o_saturated (saturated),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    gradient_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_action     (action),
        .i_coord_a    (coord_a),
        .i_coord_b    (coord_b),
        .i_coord_c    (coord_c),
        .i_potential  (potential),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_gradient   (gradient),
        .i_saturated  (saturated),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_pending    (pending_results),
        .o_mismatches (mismatch_count)
    );

    // Watchdog: anything that hangs lands here.
    initial begin : watchdog
        #LIMIT_NS;
        $display("*** FAILED ***");
        $finish;
    end

    // Result side. A requested long hold takes priority and is counted here,
    // so the block backs up while the sender keeps offering transfers.
    initial begin : sink_side
        forever begin
            @(posedge clk);
            if (holds_served < holds_asked) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
                holds_served++;
            end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic int cell_of(input logic [COORD_IN_W-1:0] a,
                                   input logic [COORD_IN_W-1:0] b,
                                   input logic [COORD_IN_W-1:0] c);
        return (int'(a) * GRID_SIDE + int'(b)) * GRID_SIDE + int'(c);
    endfunction

    // neighbor one step along the current axis, wrapping at the grid edge
    function automatic void step_along(input logic [COORD_IN_W-1:0] a,
                                       input logic [COORD_IN_W-1:0] b,
                                       input logic [COORD_IN_W-1:0] c,
                                       input int dir,
                                       output logic [COORD_IN_W-1:0] na,
                                       output logic [COORD_IN_W-1:0] nb,
                                       output logic [COORD_IN_W-1:0] nc);
        na = a;
        nb = b;
        nc = c;
        if (axis_now == AXIS_A)
            na = COORD_IN_W'((int'(a) + dir) & (GRID_SIDE - 1));
        else if (axis_now == AXIS_B)
            nb = COORD_IN_W'((int'(b) + dir) & (GRID_SIDE - 1));
        else
            nc = COORD_IN_W'((int'(c) + dir) & (GRID_SIDE - 1));
    endfunction

    function automatic bit neighbors_loaded(input logic [COORD_IN_W-1:0] a,
                                            input logic [COORD_IN_W-1:0] b,
                                            input logic [COORD_IN_W-1:0] c);
        logic [COORD_IN_W-1:0] pa, pb, pc, ma, mb, mc;
        step_along(a, b, c, 1, pa, pb, pc);
        step_along(a, b, c, -1, ma, mb, mc);
        return cell_loaded[cell_of(pa, pb, pc)] && cell_loaded[cell_of(ma, mb, mc)];
    endfunction

    // grid edges get extra weight so the wrap is hit often
    function automatic logic [COORD_IN_W-1:0] pick_coord();
        if ($urandom_range(0, 3) != 0)
            return COORD_IN_W'($urandom_range(0, GRID_SIDE - 1));
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return COORD_IN_W'(1);
            2:       return COORD_IN_W'(GRID_SIDE - 2);
            default: return COORD_IN_W'(GRID_SIDE - 1);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_potential();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return DATA_W'(int'($urandom_range(0, 2000)) - 1000);
            default: return $urandom();
        endcase
    endfunction

    // One transfer on the input channel, with an occasional idle burst first.
    task automatic push_item(input logic act, input logic [COORD_IN_W-1:0] a,
                             input logic [COORD_IN_W-1:0] b,
                             input logic [COORD_IN_W-1:0] c,
                             input logic [DATA_W-1:0] pot);
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        action    <= act;
        coord_a   <= a;
        coord_b   <= b;
        coord_c   <= c;
        potential <= pot;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        item_count++;
    endtask

    task automatic load_cell(input logic [COORD_IN_W-1:0] a, input logic [COORD_IN_W-1:0] b,
                             input logic [COORD_IN_W-1:0] c, input logic [DATA_W-1:0] pot);
        push_item(ACT_LOAD, a, b, c, pot);
        cell_loaded[cell_of(a, b, c)] = 1'b1;
    endtask

    // potential rides along with junk; the block must ignore it on a query
    task automatic query_cell(input logic [COORD_IN_W-1:0] a, input logic [COORD_IN_W-1:0] b,
                              input logic [COORD_IN_W-1:0] c);
        push_item(ACT_QUERY, a, b, c, $urandom());
        recent_cells.push_back({a, b, c});
        if (recent_cells.size() > RECENT_MAX)
            void'(recent_cells.pop_front());
    endtask

    task automatic load_neighbors(input logic [COORD_IN_W-1:0] a,
                                  input logic [COORD_IN_W-1:0] b,
                                  input logic [COORD_IN_W-1:0] c);
        logic [COORD_IN_W-1:0] na, nb, nc;
        step_along(a, b, c, 1, na, nb, nc);
        load_cell(na, nb, nc, pick_potential());
        step_along(a, b, c, -1, na, nb, nc);
        load_cell(na, nb, nc, pick_potential());
    endtask

    // Sender stops until every expected result is back, then lets trailing loads finish.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Config changes only with the block empty; each write is read back.
    task automatic set_config(input logic [AXIS_W-1:0] axis, input logic [INV_W-1:0] inv);
        drain();
        apb_access(APB_WR, ADDR_AXIS, PDATA_W'(axis));
        apb_access(APB_RD, ADDR_AXIS, '0);
        apb_access(APB_WR, ADDR_INV, PDATA_W'(inv));
        apb_access(APB_RD, ADDR_INV, '0);
        axis_now = axis;
    endtask

    // Mostly well-formed work: load both neighbors then query, or re-query a
    // known cell; the rest are stray loads that also overwrite old neighbors.
    task automatic random_step();
        logic [COORD_IN_W-1:0] a, b, c;
        int                    pick;
        pick = $urandom_range(0, 99);
        a    = pick_coord();
        b    = pick_coord();
        c    = pick_coord();
        if (pick < 45) begin
            load_neighbors(a, b, c);
            query_cell(a, b, c);
        end else if (pick < 75) begin
            if (recent_cells.size() > 0)
                {a, b, c} = recent_cells[$urandom_range(0, recent_cells.size() - 1)];
            if (!neighbors_loaded(a, b, c))
                load_neighbors(a, b, c);
            query_cell(a, b, c);
        end else begin
            load_cell(a, b, c, pick_potential());
        end
    endtask

    task automatic run_phase(input logic [AXIS_W-1:0] axis, input logic [INV_W-1:0] inv,
                             input int count, input bit src_idle, input bit sink_idle,
                             input bit long_hold);
        int target;
        set_config(axis, inv);
        src_idle_on  = src_idle;
        sink_idle_on = sink_idle;
        if (long_hold)
            holds_asked++;
        target = item_count + count;
        while (item_count < target)
            random_step();
    endtask

    initial begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, on reset config (first index, inv = 0.5).
        // Positive overflow across the low wrap: 7FFFFFFF - 80000000.
        load_cell(5'd1, 5'd0, 5'd0, 32'h7FFF_FFFF);
        load_cell(5'd31, 5'd0, 5'd0, 32'h8000_0000);
        query_cell(5'd0, 5'd0, 5'd0);
        // Most negative difference across the high wrap, just inside range.
        load_cell(5'd0, 5'd0, 5'd0, 32'h8000_0000);
        load_cell(5'd30, 5'd0, 5'd0, 32'h7FFF_FFFF);
        query_cell(5'd31, 5'd0, 5'd0);
        // Equal neighbors give zero.
        load_cell(5'd2, 5'd0, 5'd0, 32'h8000_0000);
        query_cell(5'd1, 5'd0, 5'd0);
        // Half-way ties: -1/2 rounds up to 0, +1/2 rounds up to 1.
        load_cell(5'd2, 5'd3, 5'd4, 32'h0000_0001);
        load_cell(5'd4, 5'd3, 5'd4, 32'h0000_0000);
        query_cell(5'd3, 5'd3, 5'd4);
        load_cell(5'd2, 5'd7, 5'd7, 32'h0000_0000);
        load_cell(5'd4, 5'd7, 5'd7, 32'h0000_0001);
        query_cell(5'd3, 5'd7, 5'd7);
        // All-ones coordinates, all-ones junk potential on the query.
        load_cell(5'd0, 5'd31, 5'd31, 32'hFFFF_FFFF);
        load_cell(5'd30, 5'd31, 5'd31, 32'h1234_5678);
        push_item(ACT_QUERY, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF);
        // Overwrite a neighbor, then query again.
        load_cell(5'd1, 5'd0, 5'd0, 32'h0001_0000);
        query_cell(5'd0, 5'd0, 5'd0);

        // Random phases over all axis codes and the scale extremes.
        run_phase(AXIS_B, INV_W'(65536), 190, 1'b1, 1'b1, 1'b1);
        run_phase(AXIS_C, INV_W'(0), 160, 1'b1, 1'b1, 1'b0);
        run_phase(AXIS_C_ALIAS, {INV_W{1'b1}}, 190, 1'b1, 1'b0, 1'b0);
        run_phase(AXIS_A, INV_W'($urandom_range(0, 16777215)), 190, 1'b0, 1'b1, 1'b0);
        run_phase(AXIS_B, INV_W'($urandom_range(1, 131072)), 190, 1'b1, 1'b1, 1'b0);
        // last stretch runs flat out on both sides
        run_phase(AXIS_C, INV_W'($urandom_range(0, 16777215)), 200, 1'b0, 1'b0, 1'b0);

        drain();
        repeat (TAIL) @(posedge clk);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
